[sv/fcv_pkg.sv]
// Package for the frame checksum verifier.
// Holds shared widths, the default header length and the stage/result structs.
// No dependencies.
package fcv_pkg;

   // default header size in bytes (range 0..4)
   localparam int DEF_HEADER_BYTES = 4;

   localparam int BYTE_W = 8;
   localparam int SUM_W  = 16;

   // empty payload gives an all-ones checksum
   localparam logic [SUM_W-1:0] SUM_ONES = 16'hFFFF;

   // contents of the input register
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [BYTE_W-1:0] data;
   } fcv_stage_type;

   // one verification result
   typedef struct packed {
      logic             checksum_ok;
      logic [SUM_W-1:0] computed_checksum;
      logic [SUM_W-1:0] stored_checksum;
      logic             too_short;
   } fcv_result_type;

endpackage

[sv/fcv_in_stage.sv]
// Input register of the frame checksum verifier.
// Captures one byte transaction and holds it until the datapath advances.
// Depends on fcv_pkg.
module fcv_in_stage
   import fcv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_last_byte,
   input  logic                advance,
   output fcv_stage_type       stage
);

   logic              valid_ff, valid_in;
   logic              last_ff, last_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              load;

   // register is free when empty or draining this cycle
   assign load      = !valid_ff || advance;
   assign req_stall = !load;

   // next contents
   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = req_valid;
         last_in  = req_last_byte;
         data_in  = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      last_ff <= last_in;
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.last  = last_ff;
   assign stage.data  = data_ff;

endmodule

[sv/fcv_accum.sv]
// Frame state and checksum arithmetic of the frame checksum verifier.
// Tracks byte position, stored checksum and the ones' complement sum.
// Depends on fcv_pkg.
module fcv_accum
   import fcv_pkg::*;
#(
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
   input  logic           clock,
   input  logic           reset,
   input  fcv_stage_type  stage,
   input  logic           advance,
   output fcv_result_type result
);

   localparam int POS_W = $clog2(HEADER_BYTES + 3);
   localparam logic [POS_W-1:0] POS_CK_LO = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_CK_HI = POS_W'(HEADER_BYTES + 1);
   localparam logic [POS_W-1:0] POS_PAY   = POS_W'(HEADER_BYTES + 2);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SUM_W-1:0]  chk_ff, chk_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic              odd_ff, odd_in;

   logic              is_lo, is_hi, is_pay;
   logic [SUM_W-1:0]  addend;
   logic [SUM_W:0]    sum_raw;
   logic [SUM_W-1:0]  sum_new;
   logic [SUM_W-1:0]  stored;
   logic [SUM_W-1:0]  computed;

   // byte position decode
   assign is_lo  = (pos_ff == POS_CK_LO);
   assign is_hi  = (pos_ff == POS_CK_HI);
   assign is_pay = (pos_ff == POS_PAY);

   // payload word: completes a held low byte, or stands alone as a low byte
   assign addend  = odd_ff ? {stage.data, held_ff} : {{(SUM_W-BYTE_W){1'b0}}, stage.data};
   assign sum_raw = {1'b0, sum_ff} + {1'b0, addend};
   assign sum_new = sum_raw[SUM_W-1:0] + SUM_W'(sum_raw[SUM_W]);

   // next state
   always_comb begin
      pos_in  = pos_ff;
      chk_in  = chk_ff;
      sum_in  = sum_ff;
      held_in = held_ff;
      odd_in  = odd_ff;
      if (advance) begin
         if (stage.last) begin
            pos_in  = '0;
            chk_in  = '0;
            sum_in  = '0;
            held_in = '0;
            odd_in  = 1'b0;
         end else begin
            if (!is_pay) begin
               pos_in = pos_ff + POS_W'(1);
            end
            if (is_lo) begin
               chk_in = {{(SUM_W-BYTE_W){1'b0}}, stage.data};
            end else if (is_hi) begin
               chk_in = {stage.data, chk_ff[BYTE_W-1:0]};
            end else if (is_pay) begin
               if (odd_ff) begin
                  sum_in  = sum_new;
                  held_in = '0;
                  odd_in  = 1'b0;
               end else begin
                  held_in = stage.data;
                  odd_in  = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         chk_ff  <= '0;
         sum_ff  <= '0;
         held_ff <= '0;
         odd_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         chk_ff  <= chk_in;
         sum_ff  <= sum_in;
         held_ff <= held_in;
         odd_ff  <= odd_in;
      end
   end

   // result for a final byte in the input register
   assign stored   = is_hi ? {stage.data, chk_ff[BYTE_W-1:0]} : chk_ff;
   assign computed = is_pay ? ~sum_new : SUM_ONES;

   always_comb begin
      if (pos_ff < POS_CK_HI) begin
         result.checksum_ok       = 1'b0;
         result.computed_checksum = '0;
         result.stored_checksum   = '0;
         result.too_short         = 1'b1;
      end else begin
         result.checksum_ok       = (computed == stored);
         result.computed_checksum = computed;
         result.stored_checksum   = stored;
         result.too_short         = 1'b0;
      end
   end

endmodule

[sv/fcv_out_stage.sv]
// Result register of the frame checksum verifier.
// Holds one result transaction until the receiver takes it.
// Depends on fcv_pkg.
module fcv_out_stage
   import fcv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  fcv_result_type result,
   output logic           out_free,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output fcv_result_type rsp_result
);

   logic           valid_ff, valid_in;
   fcv_result_type res_ff, res_in;

   // free when empty or being taken this cycle
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (out_free) begin
         valid_in = load;
      end
      if (load) begin
         res_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = res_ff;

endmodule

[sv/frame_checksum_verifier.sv]
// Top level of the frame checksum verifier.
// Ties input register, checksum state/arithmetic and result register together.
// Depends on fcv_pkg, fcv_in_stage, fcv_accum, fcv_out_stage.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  data_byte[7:0], last_byte
//   rsp_      out        rsp_valid/rsp_stall  checksum_ok, computed_checksum[15:0],
//                                             stored_checksum[15:0], too_short
//
// One byte per cycle while the result register can take each final byte; the 16-bit
// end-around adder sits between the input register and the result register.
// rsp_valid rises when the final byte's result moves from the input register into the result register.
// Synchronous reset clears the frame state and both valid flags.
// A stalled result holds a final byte in the input register, which then stalls
// the request channel; non-final bytes never wait on the result side.
module frame_checksum_verifier
   import fcv_pkg::*;
#(
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_checksum_ok,
   output logic [SUM_W-1:0]  rsp_computed_checksum,
   output logic [SUM_W-1:0]  rsp_stored_checksum,
   output logic              rsp_too_short
);

   fcv_stage_type  stage;
   fcv_result_type result;
   fcv_result_type rsp_result;
   logic           out_free;
   logic           advance;
   logic           load;

   // a byte moves on unless it is final and the result register is busy
   assign advance = stage.valid && (!stage.last || out_free);
   assign load    = advance && stage.last;

   fcv_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .stage         (stage)
   );

   fcv_accum #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .result  (result)
   );

   fcv_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_checksum_ok       = rsp_result.checksum_ok;
   assign rsp_computed_checksum = rsp_result.computed_checksum;
   assign rsp_stored_checksum   = rsp_result.stored_checksum;
   assign rsp_too_short         = rsp_result.too_short;

`ifndef SYNTH
   // an empty input register never pushes back
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !stage.valid |-> !req_stall)
      else $error("input stalled while input register empty");

   // a loaded result is presented next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded result not presented");

   // short frames report no checksum values
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_short |->
         !rsp_checksum_ok && rsp_computed_checksum == '0 && rsp_stored_checksum == '0)
      else $error("short frame result not cleared");

   // match flag agrees with the reported values
   a_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_too_short |->
         rsp_checksum_ok == (rsp_computed_checksum == rsp_stored_checksum))
      else $error("match flag inconsistent");
`endif

endmodule

[test/frame_result_checker.sv]
// Result checker for the frame checksum verifier testbench.
// Watches both channels, predicts each frame verdict and compares it.
// Depends on fcv_pkg.
`timescale 1ns / 100ps

module frame_result_checker
   import fcv_pkg::*;
#(
   parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_last_byte,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_checksum_ok,
   input  logic [SUM_W-1:0]  rsp_computed_checksum,
   input  logic [SUM_W-1:0]  rsp_stored_checksum,
   input  logic              rsp_too_short,
   output int                mismatch_count,
   output int                expected_left,
   output int                frames_seen,
   output int                short_seen,
   output int                match_seen
);

   // predicted frame state
   logic [2:0]        frame_pos;
   logic [SUM_W-1:0]  stored_sum;
   logic [SUM_W-1:0]  word_sum;
   logic [BYTE_W-1:0] pend_low;
   logic              pend_odd;

   // verdicts waiting for their response transaction
   fcv_result_type verdict_q[$];

   initial begin
      mismatch_count = 0;
      expected_left  = 0;
      frames_seen    = 0;
      short_seen     = 0;
      match_seen     = 0;
   end

   // 16-bit ones' complement add with end-around carry
   function automatic logic [SUM_W-1:0] ones_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = a + b;
      return s[SUM_W-1:0] + s[SUM_W];
   endfunction

   task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                              input logic [SUM_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      fcv_result_type want;
      logic [SUM_W-1:0] total;
      int pos;

      if (reset) begin
         frame_pos  = '0;
         stored_sum = '0;
         word_sum   = '0;
         pend_low   = '0;
         pend_odd   = 1'b0;
         verdict_q.delete();
      end else begin
         // compare a response transaction against the oldest verdict
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected result ok=%b computed=%h stored=%h short=%b",
                        $time, rsp_checksum_ok, rsp_computed_checksum,
                        rsp_stored_checksum, rsp_too_short);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               check_field("checksum_ok", want.checksum_ok, rsp_checksum_ok);
               check_field("computed_checksum", want.computed_checksum,
                           rsp_computed_checksum);
               check_field("stored_checksum", want.stored_checksum, rsp_stored_checksum);
               check_field("too_short", want.too_short, rsp_too_short);
            end
         end

         // advance the predicted frame state on each byte transaction
         if (req_valid && !req_stall) begin
            pos = int'(frame_pos);
            if (pos == HEADER_BYTES) begin
               stored_sum = {8'h00, req_data_byte};
            end else if (pos == HEADER_BYTES + 1) begin
               stored_sum[15:8] = req_data_byte;
            end else if (pos > HEADER_BYTES + 1) begin
               if (pend_odd) begin
                  word_sum = ones_add(word_sum, {req_data_byte, pend_low});
                  pend_odd = 1'b0;
                  pend_low = '0;
               end else begin
                  pend_low = req_data_byte;
                  pend_odd = 1'b1;
               end
            end
            // position saturates once the payload starts
            if (pos < HEADER_BYTES + 2)
               frame_pos = 3'(pos + 1);

            if (req_last_byte) begin
               frames_seen++;
               if (pos < HEADER_BYTES + 1) begin
                  // frame ended before the stored checksum was complete
                  want.checksum_ok       = 1'b0;
                  want.computed_checksum = '0;
                  want.stored_checksum   = '0;
                  want.too_short         = 1'b1;
                  short_seen++;
               end else begin
                  total = pend_odd ? ones_add(word_sum, {8'h00, pend_low}) : word_sum;
                  want.computed_checksum = ~total;
                  want.stored_checksum   = stored_sum;
                  want.checksum_ok       = (~total == stored_sum);
                  want.too_short         = 1'b0;
                  if (want.checksum_ok)
                     match_seen++;
               end
               verdict_q.push_back(want);
               frame_pos  = '0;
               stored_sum = '0;
               word_sum   = '0;
               pend_low   = '0;
               pend_odd   = 1'b0;
            end
         end
      end
      expected_left = verdict_q.size();
   end

endmodule

[test/frame_checksum_verifier_tb.sv]
// Testbench top for the frame checksum verifier.
// Drives byte frames and receiver stalls; frame_result_checker does the checking.
// Depends on fcv_pkg, frame_checksum_verifier and frame_result_checker.
`timescale 1ns / 100ps

module frame_checksum_verifier_tb;
   import fcv_pkg::*;

   localparam int HDR = DEF_HEADER_BYTES;
   localparam int PHASE_BYTES = 250;

   // how the stored checksum of a generated frame relates to its payload
   typedef enum int {CK_GOOD, CK_BITFLIP, CK_RANDOM} ck_kind_type;

   logic              clock;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic              rsp_checksum_ok;
   logic [SUM_W-1:0]  rsp_computed_checksum;
   logic [SUM_W-1:0]  rsp_stored_checksum;
   logic              rsp_too_short;

   int mismatch_count, expected_left, frames_seen, short_seen, match_seen;
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int bytes_sent      = 0;
   int phase_start;

   logic [BYTE_W-1:0] frame_q[$];

   frame_checksum_verifier #(.HEADER_BYTES(HDR)) dut (.*);

   frame_result_checker #(.HEADER_BYTES(HDR)) check (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver backpressure
   always @(posedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

   initial begin
      #5_000_000;
      $display("frame_checksum_verifier: mismatch");
      $finish;
   end

   // one byte transaction, with optional idle cycles ahead of it
   task automatic push_byte(input logic [BYTE_W-1:0] value, input logic is_last);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_last_byte <= is_last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_q.size(); i++)
         push_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // hold off the sender until every verdict has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (expected_left != 0);
      @(posedge clock);
   endtask

   // inverted ones' complement sum of the payload in frame_q
   function automatic logic [SUM_W-1:0] payload_checksum();
      logic [31:0] acc;
      int i;
      acc = 0;
      for (i = HDR + 2; i < frame_q.size(); i += 2)
         acc += (i + 1 < frame_q.size()) ? {frame_q[i+1], frame_q[i]}
                                         : {8'h00, frame_q[i]};
      acc = acc[15:0] + acc[31:16];
      acc = acc[15:0] + acc[31:16];
      return ~acc[15:0];
   endfunction

   task automatic build_full_frame(input int payload_len, input ck_kind_type kind);
      logic [SUM_W-1:0] ck;
      int i, r;
      frame_q.delete();
      for (i = 0; i < HDR + 2; i++)
         frame_q.push_back(8'($urandom_range(255)));
      // lean on all-ones and all-zeros bytes to stress the carry path
      for (i = 0; i < payload_len; i++) begin
         r = $urandom_range(9);
         frame_q.push_back(r == 0 ? 8'hFF : r == 1 ? 8'h00 : 8'($urandom_range(255)));
      end
      case (kind)
         CK_GOOD:    ck = payload_checksum();
         CK_BITFLIP: ck = payload_checksum() ^ (16'h0001 << $urandom_range(15));
         default:    ck = 16'($urandom_range(16'hFFFF));
      endcase
      frame_q[HDR]     = ck[7:0];
      frame_q[HDR + 1] = ck[15:8];
   endtask

   task automatic random_frames(input int byte_budget);
      int r, len;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < byte_budget) begin
         r = $urandom_range(99);
         if (r < 12) begin
            // ends inside the header or on the low checksum byte
            frame_q.delete();
            len = $urandom_range(HDR + 1, 1);
            repeat (len)
               frame_q.push_back(8'($urandom_range(255)));
         end else begin
            len = ($urandom_range(99) < 5) ? $urandom_range(40, 17) : $urandom_range(16);
            build_full_frame(len, r < 55 ? CK_GOOD : r < 75 ? CK_BITFLIP : CK_RANDOM);
         end
         send_frame();
      end
   endtask

   initial begin
      repeat (11)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames: shortest, short at low checksum byte, empty payloads,
      // odd trailing byte with end-around carry
      frame_q = '{8'hFF};
      send_frame();
      frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hA5};
      send_frame();
      frame_q = '{8'h01, 8'h02, 8'h03, 8'h04, 8'hFF, 8'hFF};
      send_frame();
      frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      frame_q = '{8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h01};
      send_frame();
      wait_for_results();

      // random frames under each flow-control mix
      sender_idle_pct = 0;
      stall_pct       = 0;
      random_frames(PHASE_BYTES);
      wait_for_results();

      sender_idle_pct = 70;
      stall_pct       = 0;
      random_frames(PHASE_BYTES);
      wait_for_results();

      sender_idle_pct = 0;
      stall_pct       = 70;
      random_frames(PHASE_BYTES);
      wait_for_results();

      sender_idle_pct = 24;
      stall_pct       = 24;
      random_frames(PHASE_BYTES);
      wait_for_results();

      // catch any stray late result
      stall_pct = 0;
      repeat (8)
         @(posedge clock);

      $display("Sent %0d bytes in %0d frames under four flow-control mixes;", bytes_sent,
               frames_seen);
      $display("%0d frames matched their checksum, %0d were cut short.", match_seen,
               short_seen);
      if (mismatch_count == 0 && expected_left == 0)
         $display("frame_checksum_verifier: match");
      else
         $display("frame_checksum_verifier: mismatch");
      $finish;
   end

endmodule

[sim.f]
sv/fcv_pkg.sv
sv/fcv_in_stage.sv
sv/fcv_accum.sv
sv/fcv_out_stage.sv
sv/frame_checksum_verifier.sv
test/frame_result_checker.sv
test/frame_checksum_verifier_tb.sv
